>>> hdl/lorenz_euler_plotter_core_macros.svh
// Assertion macros shared by the Lorenz plotter RTL.
`ifndef LORENZ_EULER_PLOTTER_CORE_MACROS_SVH
`define LORENZ_EULER_PLOTTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lep_pkg.sv
// Package with the constants, types and helper functions of the Lorenz plotter.
`timescale 1ns / 1ps
`default_nettype none

package lep_pkg;

   localparam int FRAC_BITS = 24;
   localparam int STATE_W   = 32;
   localparam int DERIV_W   = 40;   // holds any derivative value
   localparam int SUM_W     = 42;   // state plus scaled derivative before saturation
   localparam int OPND_W    = 33;   // multiplier operand width
   localparam int PROD_W    = 2 * OPND_W;
   localparam int PIX_ACC_W = 46;   // origin plus zoomed projection, fixed point
   localparam int PIX_INT_W = PIX_ACC_W - FRAC_BITS;
   localparam int PIX_W     = 16;
   localparam int K_SHIFT   = 32;
   localparam int CNT_W     = 5;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   // Projection slope 0.292893 in Q0.32.
   localparam logic signed [OPND_W-1:0] K_Q32 = 33'sd1257965856;

   localparam logic signed [STATE_W-1:0] RESET_X = 32'sd51196044;
   localparam logic signed [STATE_W-1:0] RESET_Y = 32'sd26550651;
   localparam logic signed [STATE_W-1:0] RESET_Z = 32'sd262125238;

   localparam logic [5:0]         SIGMA_RST    = 6'd5;
   localparam logic [5:0]         RHO_RST      = 6'd15;
   localparam logic [5:0]         BETA_RST     = 6'd1;
   localparam logic [23:0]        STEP_RST     = 24'd1678;
   localparam logic [9:0]         ZOOM_X_RST   = 10'd90;
   localparam logic [9:0]         ZOOM_Y_RST   = 10'd90;
   localparam logic signed [15:0] ORIGIN_X_RST = 16'sd100;
   localparam logic signed [15:0] ORIGIN_Y_RST = 16'sd1000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO       = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM_X    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM_Y    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y  = 4'd7;

   // Request kinds.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // Sequencer steps of one Euler step item.
   localparam logic [CNT_W-1:0] SQ_ZX      = 5'd0;
   localparam logic [CNT_W-1:0] SQ_RHOX    = 5'd1;
   localparam logic [CNT_W-1:0] SQ_XY      = 5'd2;
   localparam logic [CNT_W-1:0] SQ_BETAZ   = 5'd3;
   localparam logic [CNT_W-1:0] SQ_SIGMA   = 5'd4;
   localparam logic [CNT_W-1:0] SQ_DY_HI   = 5'd5;
   localparam logic [CNT_W-1:0] SQ_DY_LO   = 5'd6;
   localparam logic [CNT_W-1:0] SQ_DZ_HI   = 5'd7;
   localparam logic [CNT_W-1:0] SQ_DZ_LO   = 5'd8;
   localparam logic [CNT_W-1:0] SQ_DX_HI   = 5'd9;
   localparam logic [CNT_W-1:0] SQ_DX_LO   = 5'd10;
   localparam logic [CNT_W-1:0] SQ_X_DONE  = 5'd11;
   localparam logic [CNT_W-1:0] SQ_KX      = 5'd12;
   localparam logic [CNT_W-1:0] SQ_KX_DONE = 5'd13;
   localparam logic [CNT_W-1:0] SQ_PIX_X   = 5'd14;
   localparam logic [CNT_W-1:0] SQ_PIX_Y   = 5'd15;
   localparam logic [CNT_W-1:0] SQ_LAST    = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } seq_state_type;

   // Clamp a wide sum to the signed state range.
   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic upper_ones;
      logic upper_zeros;
      upper_ones  = &v[SUM_W-1:STATE_W-1];
      upper_zeros = ~|v[SUM_W-1:STATE_W-1];
      if (upper_ones || upper_zeros) begin
         return v[STATE_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   // Truncate a fixed point pixel value toward zero and clamp it to 16 bits.
   function automatic logic signed [PIX_W-1:0] pixel_round(
      input logic signed [PIX_ACC_W-1:0] v);
      logic signed [PIX_ACC_W-1:0] adj;
      logic signed [PIX_ACC_W-1:0] shifted;
      logic signed [PIX_INT_W-1:0] q;
      logic                        upper_ones;
      logic                        upper_zeros;
      adj = v;
      if (v[PIX_ACC_W-1]) begin
         adj = v + PIX_ACC_W'((64'd1 << FRAC_BITS) - 64'd1);
      end
      shifted     = adj >>> FRAC_BITS;
      q           = shifted[PIX_INT_W-1:0];
      upper_ones  = &q[PIX_INT_W-1:PIX_W-1];
      upper_zeros = ~|q[PIX_INT_W-1:PIX_W-1];
      if (upper_ones || upper_zeros) begin
         return q[PIX_W-1:0];
      end else if (q[PIX_INT_W-1]) begin
         return {1'b1, {(PIX_W-1){1'b0}}};
      end else begin
         return {1'b0, {(PIX_W-1){1'b1}}};
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/lorenz_euler_plotter_core.sv
// Lorenz system integrator with oblique projection to pixel coordinates, one shared multiplier.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_stall  | req_type, req_init_x/y/z
//   rsp_    | out       | rsp_valid/rsp_stall  | rsp_pixel_x/y, rsp_pos_x/y/z
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A load word gives no response word.
// A step word runs through the issue slots of the single 33x33 multiplier, a slot for the
// last product and the finish state that hands the result to the output register.
// The multiplier is the bottleneck: every product of the step goes through it in turn.
// Reset is synchronous; it restores the register defaults and the initial state.
// A stalled response word waits in the output register while the next step runs; a step
// that finishes before that word is taken holds in its final state.
`timescale 1ns / 1ps
`default_nettype none
`include "lorenz_euler_plotter_core_macros.svh"

module lorenz_euler_plotter_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [31:0]          req_init_x,
   input  logic signed [31:0]          req_init_y,
   input  logic signed [31:0]          req_init_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_pixel_x,
   output logic signed [15:0]          rsp_pixel_y,
   output logic signed [31:0]          rsp_pos_x,
   output logic signed [31:0]          rsp_pos_y,
   output logic signed [31:0]          rsp_pos_z,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lep_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lep_pkg::CSR_DAT_W-1:0] csr_data
);

   lep_pkg::seq_state_type state_ff, state_in;
   logic [lep_pkg::CNT_W-1:0] count_ff, count_in;

   logic signed [lep_pkg::STATE_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [lep_pkg::DERIV_W-1:0]   dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic signed [lep_pkg::SUM_W-1:0]     t_ff, t_in;
   logic signed [lep_pkg::OPND_W-1:0]    kx_ff, kx_in;
   logic signed [lep_pkg::PIX_ACC_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [lep_pkg::PROD_W-1:0]    prod_ff, prod_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [lep_pkg::PIX_W-1:0]   rsp_pixel_x_ff, rsp_pixel_x_in;
   logic signed [lep_pkg::PIX_W-1:0]   rsp_pixel_y_ff, rsp_pixel_y_in;
   logic signed [lep_pkg::STATE_W-1:0] rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [lep_pkg::STATE_W-1:0] rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [lep_pkg::STATE_W-1:0] rsp_pos_z_ff, rsp_pos_z_in;

   logic [5:0]         sigma_ff, rho_ff, beta_ff;
   logic [23:0]        step_size_ff;
   logic [9:0]         zoom_x_ff, zoom_y_ff;
   logic signed [15:0] origin_x_ff, origin_y_ff;

   logic signed [lep_pkg::OPND_W-1:0]    opa, opb;
   logic signed [lep_pkg::OPND_W-1:0]    dt_opnd;
   logic signed [lep_pkg::PROD_W-1:0]    prod_frac;
   logic signed [lep_pkg::PROD_W-1:0]    prod_k;
   logic signed [lep_pkg::STATE_W-1:0]   euler_base;
   logic signed [lep_pkg::SUM_W-1:0]     euler_sum;
   logic signed [lep_pkg::STATE_W-1:0]   euler_sat;
   logic                                 req_fire;
   logic                                 rsp_free;

   assign req_stall   = (state_ff != lep_pkg::ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = rsp_pixel_x_ff;
   assign rsp_pixel_y = rsp_pixel_y_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_pos_z   = rsp_pos_z_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff     <= lep_pkg::SIGMA_RST;
         rho_ff       <= lep_pkg::RHO_RST;
         beta_ff      <= lep_pkg::BETA_RST;
         step_size_ff <= lep_pkg::STEP_RST;
         zoom_x_ff    <= lep_pkg::ZOOM_X_RST;
         zoom_y_ff    <= lep_pkg::ZOOM_Y_RST;
         origin_x_ff  <= lep_pkg::ORIGIN_X_RST;
         origin_y_ff  <= lep_pkg::ORIGIN_Y_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lep_pkg::CSR_SIGMA:     sigma_ff     <= csr_data[5:0];
            lep_pkg::CSR_RHO:       rho_ff       <= csr_data[5:0];
            lep_pkg::CSR_BETA:      beta_ff      <= csr_data[5:0];
            lep_pkg::CSR_STEP_SIZE: step_size_ff <= csr_data[23:0];
            lep_pkg::CSR_ZOOM_X:    zoom_x_ff    <= csr_data[9:0];
            lep_pkg::CSR_ZOOM_Y:    zoom_y_ff    <= csr_data[9:0];
            lep_pkg::CSR_ORIGIN_X:  origin_x_ff  <= $signed(csr_data[15:0]);
            lep_pkg::CSR_ORIGIN_Y:  origin_y_ff  <= $signed(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   assign dt_opnd = $signed({{(lep_pkg::OPND_W - 24){1'b0}}, step_size_ff});

   // Operand select for the shared multiplier.
   always_comb begin
      opa = '0;
      opb = '0;
      case (count_ff)
         lep_pkg::SQ_ZX: begin
            opa = lep_pkg::OPND_W'(z_ff);
            opb = lep_pkg::OPND_W'(x_ff);
         end
         lep_pkg::SQ_RHOX: begin
            opa = $signed({{(lep_pkg::OPND_W - 6){1'b0}}, rho_ff});
            opb = lep_pkg::OPND_W'(x_ff);
         end
         lep_pkg::SQ_XY: begin
            opa = lep_pkg::OPND_W'(x_ff);
            opb = lep_pkg::OPND_W'(y_ff);
         end
         lep_pkg::SQ_BETAZ: begin
            opa = $signed({{(lep_pkg::OPND_W - 6){1'b0}}, beta_ff});
            opb = lep_pkg::OPND_W'(z_ff);
         end
         lep_pkg::SQ_SIGMA: begin
            opa = $signed({{(lep_pkg::OPND_W - 6){1'b0}}, sigma_ff});
            opb = lep_pkg::OPND_W'(y_ff) - lep_pkg::OPND_W'(x_ff);
         end
         // Each derivative is split into a floored upper part and a fraction so that the
         // product with dt stays within the multiplier.
         lep_pkg::SQ_DY_HI: begin
            opa = lep_pkg::OPND_W'($signed(dy_ff[lep_pkg::DERIV_W-1:lep_pkg::FRAC_BITS]));
            opb = dt_opnd;
         end
         lep_pkg::SQ_DY_LO: begin
            opa = $signed({{(lep_pkg::OPND_W - lep_pkg::FRAC_BITS){1'b0}},
                           dy_ff[lep_pkg::FRAC_BITS-1:0]});
            opb = dt_opnd;
         end
         lep_pkg::SQ_DZ_HI: begin
            opa = lep_pkg::OPND_W'($signed(dz_ff[lep_pkg::DERIV_W-1:lep_pkg::FRAC_BITS]));
            opb = dt_opnd;
         end
         lep_pkg::SQ_DZ_LO: begin
            opa = $signed({{(lep_pkg::OPND_W - lep_pkg::FRAC_BITS){1'b0}},
                           dz_ff[lep_pkg::FRAC_BITS-1:0]});
            opb = dt_opnd;
         end
         lep_pkg::SQ_DX_HI: begin
            opa = lep_pkg::OPND_W'($signed(dx_ff[lep_pkg::DERIV_W-1:lep_pkg::FRAC_BITS]));
            opb = dt_opnd;
         end
         lep_pkg::SQ_DX_LO: begin
            opa = $signed({{(lep_pkg::OPND_W - lep_pkg::FRAC_BITS){1'b0}},
                           dx_ff[lep_pkg::FRAC_BITS-1:0]});
            opb = dt_opnd;
         end
         lep_pkg::SQ_KX: begin
            opa = lep_pkg::OPND_W'(x_ff);
            opb = lep_pkg::K_Q32;
         end
         lep_pkg::SQ_PIX_X: begin
            opa = $signed({{(lep_pkg::OPND_W - 10){1'b0}}, zoom_x_ff});
            opb = lep_pkg::OPND_W'(y_ff) - kx_ff;
         end
         lep_pkg::SQ_PIX_Y: begin
            opa = $signed({{(lep_pkg::OPND_W - 10){1'b0}}, zoom_y_ff});
            opb = lep_pkg::OPND_W'(z_ff) + kx_ff;
         end
         default: ;
      endcase
   end

   assign prod_in   = opa * opb;
   assign prod_frac = prod_ff >>> lep_pkg::FRAC_BITS;
   assign prod_k    = prod_ff >>> lep_pkg::K_SHIFT;

   // One adder forms old state + upper product + shifted fraction product for all three axes.
   always_comb begin
      case (count_ff)
         lep_pkg::SQ_DZ_HI:  euler_base = y_ff;
         lep_pkg::SQ_DX_HI:  euler_base = z_ff;
         default:            euler_base = x_ff;
      endcase
   end

   assign euler_sum = lep_pkg::SUM_W'(euler_base) + t_ff
                    + $signed(prod_frac[lep_pkg::SUM_W-1:0]);
   assign euler_sat = lep_pkg::sat_state(euler_sum);

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      dz_in          = dz_ff;
      t_in           = t_ff;
      kx_in          = kx_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_pixel_x_in = rsp_pixel_x_ff;
      rsp_pixel_y_in = rsp_pixel_y_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_pos_z_in   = rsp_pos_z_ff;

      case (state_ff)
         lep_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_type == lep_pkg::REQ_LOAD) begin
                  x_in = req_init_x;
                  y_in = req_init_y;
                  z_in = req_init_z;
               end else begin
                  state_in = lep_pkg::ST_RUN;
                  count_in = lep_pkg::SQ_ZX;
               end
            end
         end

         lep_pkg::ST_RUN: begin
            count_in = count_ff + 1'b1;
            // Each slot consumes the product issued in the slot before it.
            case (count_ff)
               lep_pkg::SQ_RHOX:
                  dy_in = -lep_pkg::DERIV_W'(y_ff) - $signed(prod_frac[lep_pkg::DERIV_W-1:0]);
               lep_pkg::SQ_XY:
                  dy_in = dy_ff + $signed(prod_ff[lep_pkg::DERIV_W-1:0]);
               lep_pkg::SQ_BETAZ:
                  dz_in = $signed(prod_frac[lep_pkg::DERIV_W-1:0]);
               lep_pkg::SQ_SIGMA:
                  dz_in = dz_ff - $signed(prod_ff[lep_pkg::DERIV_W-1:0]);
               lep_pkg::SQ_DY_HI:
                  dx_in = $signed(prod_ff[lep_pkg::DERIV_W-1:0]);
               lep_pkg::SQ_DY_LO, lep_pkg::SQ_DZ_LO, lep_pkg::SQ_DX_LO:
                  t_in = $signed(prod_ff[lep_pkg::SUM_W-1:0]);
               lep_pkg::SQ_DZ_HI:
                  y_in = euler_sat;
               lep_pkg::SQ_DX_HI:
                  z_in = euler_sat;
               lep_pkg::SQ_X_DONE:
                  x_in = euler_sat;
               lep_pkg::SQ_KX_DONE:
                  kx_in = $signed(prod_k[lep_pkg::OPND_W-1:0]);
               lep_pkg::SQ_PIX_Y:
                  px_in = ($signed(lep_pkg::PIX_ACC_W'(origin_x_ff)) <<< lep_pkg::FRAC_BITS)
                        + $signed(prod_ff[lep_pkg::PIX_ACC_W-1:0]);
               lep_pkg::SQ_LAST: begin
                  py_in    = ($signed(lep_pkg::PIX_ACC_W'(origin_y_ff)) <<< lep_pkg::FRAC_BITS)
                           - $signed(prod_ff[lep_pkg::PIX_ACC_W-1:0]);
                  state_in = lep_pkg::ST_FINISH;
               end
               default: ;
            endcase
         end

         lep_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pixel_x_in = lep_pkg::pixel_round(px_ff);
               rsp_pixel_y_in = lep_pkg::pixel_round(py_ff);
               rsp_pos_x_in   = x_ff;
               rsp_pos_y_in   = y_ff;
               rsp_pos_z_in   = z_ff;
               state_in       = lep_pkg::ST_IDLE;
            end
         end

         default: state_in = lep_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lep_pkg::ST_IDLE;
         count_ff     <= lep_pkg::SQ_ZX;
         rsp_valid_ff <= 1'b0;
         x_ff         <= lep_pkg::RESET_X;
         y_ff         <= lep_pkg::RESET_Y;
         z_ff         <= lep_pkg::RESET_Z;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      dz_ff          <= dz_in;
      t_ff           <= t_in;
      kx_ff          <= kx_in;
      px_ff          <= px_in;
      py_ff          <= py_in;
      prod_ff        <= prod_in;
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_pos_z_ff   <= rsp_pos_z_in;
   end

   `LEP_ASSERT_NEXT(a_step_starts, req_fire && req_type == lep_pkg::REQ_STEP, state_ff == lep_pkg::ST_RUN && count_ff == lep_pkg::SQ_ZX, "step word did not start the sequencer")
   `LEP_ASSERT_NEXT(a_load_silent, req_fire && req_type == lep_pkg::REQ_LOAD, state_ff == lep_pkg::ST_IDLE && !$rose(rsp_valid_ff), "load word produced a response")
   `LEP_ASSERT_SAME(a_count_bound, state_ff == lep_pkg::ST_RUN, count_ff <= lep_pkg::SQ_LAST, "sequencer ran past its last slot")
   `LEP_ASSERT_SAME(a_word_source, $rose(rsp_valid_ff), $past(state_ff) == lep_pkg::ST_FINISH, "response word appeared outside the finish state")

endmodule

`default_nettype wire

>>> bench/lorenz_plot_check_pkg.sv
// Scoreboard for the Lorenz plotter: Euler step prediction and result checking.
`timescale 1ns / 1ps

package lorenz_plot_check_pkg;

   import lep_pkg::*;

   localparam int FRAC = 24;

   // Wide enough for every product of the step without overflow.
   typedef logic signed [95:0] wide_t;

   typedef struct {
      logic               kind;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } plot_req_t;

   typedef struct {
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } plot_point_t;

   localparam wide_t K_SLOPE = 96'sd1257965856;
   localparam wide_t ST_HI   = 96'sd2147483647;
   localparam wide_t ST_LO   = -96'sd2147483648;
   localparam wide_t PIX_HI  = 96'sd32767;
   localparam wide_t PIX_LO  = -96'sd32768;

   class plot_scoreboard;
      logic [5:0]         sigma;
      logic [5:0]         rho;
      logic [5:0]         beta;
      logic [23:0]        dt;
      logic [9:0]         zoom_x;
      logic [9:0]         zoom_y;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [31:0] st_x;
      logic signed [31:0] st_y;
      logic signed [31:0] st_z;
      plot_point_t        expected_points[$];
      int                 errors;
      int                 points_checked;
      int                 loads_seen;
      int                 steps_seen;
      int                 reg_writes;

      function new();
         errors         = 0;
         points_checked = 0;
         loads_seen     = 0;
         steps_seen     = 0;
         reg_writes     = 0;
         reset_model();
      endfunction

      function void reset_model();
         sigma    = 6'd5;
         rho      = 6'd15;
         beta     = 6'd1;
         dt       = 24'd1678;
         zoom_x   = 10'd90;
         zoom_y   = 10'd90;
         origin_x = 16'sd100;
         origin_y = 16'sd1000;
         st_x     = 32'sd51196044;
         st_y     = 32'sd26550651;
         st_z     = 32'sd262125238;
         expected_points.delete();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         reg_writes++;
         case (idx)
            CSR_SIGMA:     sigma    = data[5:0];
            CSR_RHO:       rho      = data[5:0];
            CSR_BETA:      beta     = data[5:0];
            CSR_STEP_SIZE: dt       = data[23:0];
            CSR_ZOOM_X:    zoom_x   = data[9:0];
            CSR_ZOOM_Y:    zoom_y   = data[9:0];
            CSR_ORIGIN_X:  origin_x = data[15:0];
            CSR_ORIGIN_Y:  origin_y = data[15:0];
            default: ;
         endcase
      endfunction

      function wide_t clamp(wide_t v, wide_t lo, wide_t hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Integer part of a fixed point value, rounded toward zero.
      function wide_t trunc_frac(wide_t v);
         return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
      endfunction

      // Accepted input word: a load sets the state, a step predicts one plot point.
      function void take_request(plot_req_t r);
         wide_t       x, y, z, dxd, dyd, dzd, nx, ny, nz, kx, px, py;
         plot_point_t p;
         if (r.kind == REQ_LOAD) begin
            st_x = r.x;
            st_y = r.y;
            st_z = r.z;
            loads_seen++;
            return;
         end
         steps_seen++;
         x   = wide_t'(st_x);
         y   = wide_t'(st_y);
         z   = wide_t'(st_z);
         dxd = wide_t'(sigma) * (y - x);
         dyd = wide_t'(rho) * x - y - ((z * x) >>> FRAC);
         dzd = ((x * y) >>> FRAC) - wide_t'(beta) * z;
         nx  = clamp(x + ((dxd * wide_t'(dt)) >>> FRAC), ST_LO, ST_HI);
         ny  = clamp(y + ((dyd * wide_t'(dt)) >>> FRAC), ST_LO, ST_HI);
         nz  = clamp(z + ((dzd * wide_t'(dt)) >>> FRAC), ST_LO, ST_HI);
         kx  = (nx * K_SLOPE) >>> 32;
         px  = (wide_t'(origin_x) <<< FRAC) + wide_t'(zoom_x) * (ny - kx);
         py  = (wide_t'(origin_y) <<< FRAC) - wide_t'(zoom_y) * (nz + kx);
         p.pixel_x = 16'(clamp(trunc_frac(px), PIX_LO, PIX_HI));
         p.pixel_y = 16'(clamp(trunc_frac(py), PIX_LO, PIX_HI));
         p.pos_x   = 32'(nx);
         p.pos_y   = 32'(ny);
         p.pos_z   = 32'(nz);
         st_x      = p.pos_x;
         st_y      = p.pos_y;
         st_z      = p.pos_z;
         expected_points.push_back(p);
      endfunction

      function void compare_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_point(plot_point_t got);
         plot_point_t want;
         if (expected_points.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual pixel %0d,%0d pos %0d,%0d,%0d",
                     $time, got.pixel_x, got.pixel_y, got.pos_x, got.pos_y, got.pos_z);
            return;
         end
         want = expected_points.pop_front();
         points_checked++;
         compare_field("pixel_x", want.pixel_x, got.pixel_x);
         compare_field("pixel_y", want.pixel_y, got.pixel_y);
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("pos_z", want.pos_z, got.pos_z);
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

endpackage

>>> bench/tb_top.sv
// Top level of the Lorenz plotter testbench: clock, reset, drivers, monitor and stimulus.
`timescale 1ns / 1ps

module tb_top;

   import lep_pkg::*;
   import lorenz_plot_check_pkg::*;

   localparam int ITEM_TARGET    = 1500;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh80000000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_type;
   logic signed [31:0]   req_init_x;
   logic signed [31:0]   req_init_y;
   logic signed [31:0]   req_init_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [15:0]   rsp_pixel_x;
   logic signed [15:0]   rsp_pixel_y;
   logic signed [31:0]   rsp_pos_x;
   logic signed [31:0]   rsp_pos_y;
   logic signed [31:0]   rsp_pos_z;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   plot_scoreboard sb;
   int             items_sent;
   int             idle_cycles;
   int             settings_used;
   bit             req_idle_on;
   bit             rsp_idle_on;
   bit             rsp_hold_req;

   lorenz_euler_plotter_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_init_x  (req_init_x),
      .req_init_y  (req_init_y),
      .req_init_z  (req_init_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Output side: random stall bursts, plus the long hold-off when asked for.
   initial begin : rsp_driver
      int stall_left;
      int hold_count;
      stall_left = 0;
      hold_count = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_stall <= 1'b1;
            hold_count++;
            if (hold_count == HOLD_CYCLES) begin
               rsp_hold_req = 1'b0;
               hold_count   = 0;
            end
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      plot_point_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pixel_x = rsp_pixel_x;
         got.pixel_y = rsp_pixel_y;
         got.pos_x   = rsp_pos_x;
         got.pos_y   = rsp_pos_y;
         got.pos_z   = rsp_pos_z;
         sb.check_point(got);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("lorenz_euler_plotter_core verification failed");
      $finish;
   end

   // Offer one input word and wait until the block takes it. Starts and ends at a
   // falling edge; valid stays high into the next word unless a gap is inserted.
   task automatic send(input logic kind, input logic signed [31:0] x,
                       input logic signed [31:0] y, input logic signed [31:0] z);
      plot_req_t r;
      r.kind = kind;
      r.x    = x;
      r.y    = y;
      r.z    = z;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_init_x <= x;
      req_init_y <= y;
      req_init_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   // Step words carry junk in the state fields, which the block must ignore.
   task automatic step_once();
      send(REQ_STEP, $urandom, $urandom, $urandom);
   endtask

   task automatic load_any();
      send(REQ_LOAD, $urandom, $urandom, $urandom);
   endtask

   // A start point near the attractor: x and y within +-20, z within 0..50.
   task automatic load_tame();
      send(REQ_LOAD, int'($urandom_range(0, 671088640)) - 335544320,
           int'($urandom_range(0, 671088640)) - 335544320,
           int'($urandom_range(0, 838860800)));
   endtask

   // Register write with random junk above the register width.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      logic [31:0] data;
      int          w;
      case (idx)
         CSR_SIGMA, CSR_RHO, CSR_BETA: w = 6;
         CSR_STEP_SIZE:                w = 24;
         CSR_ZOOM_X, CSR_ZOOM_Y:       w = 10;
         CSR_ORIGIN_X, CSR_ORIGIN_Y:   w = 16;
         default:                      w = 0;
      endcase
      data = $urandom;
      if (w != 0) data = (data << w) | (value & ((32'd1 << w) - 1));
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Wait until every predicted point has come back and the block has gone quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      settings_used++;
   endtask

   function automatic int pick(int lo, int hi);
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   task automatic random_config(input bit tame);
      if (tame) begin
         write_csr(CSR_SIGMA, $urandom_range(5, 15));
         write_csr(CSR_RHO, $urandom_range(10, 40));
         write_csr(CSR_BETA, $urandom_range(1, 4));
         write_csr(CSR_STEP_SIZE, $urandom_range(200, 40000));
         write_csr(CSR_ZOOM_X, $urandom_range(1, 300));
         write_csr(CSR_ZOOM_Y, $urandom_range(1, 300));
         write_csr(CSR_ORIGIN_X, int'($urandom_range(0, 3000)) - 1000);
         write_csr(CSR_ORIGIN_Y, int'($urandom_range(0, 3000)) - 1000);
      end else begin
         write_csr(CSR_SIGMA, pick(0, 63));
         write_csr(CSR_RHO, pick(0, 63));
         write_csr(CSR_BETA, pick(0, 63));
         write_csr(CSR_STEP_SIZE, pick(0, 16777215));
         write_csr(CSR_ZOOM_X, pick(0, 1023));
         write_csr(CSR_ZOOM_Y, pick(0, 1023));
         write_csr(CSR_ORIGIN_X, pick(-32768, 32767));
         write_csr(CSR_ORIGIN_Y, pick(-32768, 32767));
      end
      // Writes beyond the last register must change nothing.
      if ($urandom_range(0, 2) == 0) write_csr($urandom_range(8, 15), 0);
   endtask

   initial begin : stimulus
      int phase;
      bit tame;
      sb            = new();
      items_sent    = 0;
      settings_used = 0;
      phase         = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      rsp_hold_req  = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_LOAD;
      req_init_x    = '0;
      req_init_y    = '0;
      req_init_z    = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset state and reset registers, then the state extremes.
      repeat (3) step_once();
      send(REQ_LOAD, Q_MAX, Q_MAX, Q_MAX);
      step_once();
      send(REQ_LOAD, Q_MIN, Q_MIN, Q_MIN);
      step_once();
      send(REQ_LOAD, 32'sd0, 32'sd0, 32'sd0);
      step_once();
      send(REQ_LOAD, Q_MIN, Q_MAX, 32'sd0);
      step_once();

      // Every register at full scale, pixel origins at opposite limits.
      settle();
      write_csr(CSR_SIGMA, 63);
      write_csr(CSR_RHO, 63);
      write_csr(CSR_BETA, 63);
      write_csr(CSR_STEP_SIZE, 16777215);
      write_csr(CSR_ZOOM_X, 1023);
      write_csr(CSR_ZOOM_Y, 1023);
      write_csr(CSR_ORIGIN_X, 32767);
      write_csr(CSR_ORIGIN_Y, -32768);
      send(REQ_LOAD, Q_MAX, Q_MIN, Q_MAX);
      repeat (2) step_once();
      send(REQ_LOAD, 32'sd1, -32'sd1, 32'sd1);
      step_once();

      // Zero coefficients, zero step and zero zoom, plus writes past the last register.
      settle();
      write_csr(CSR_SIGMA, 0);
      write_csr(CSR_RHO, 0);
      write_csr(CSR_BETA, 0);
      write_csr(CSR_STEP_SIZE, 0);
      write_csr(CSR_ZOOM_X, 0);
      write_csr(CSR_ZOOM_Y, 0);
      write_csr(CSR_ORIGIN_X, 0);
      write_csr(CSR_ORIGIN_Y, 0);
      write_csr(4'd8, 0);
      write_csr(4'd15, 0);
      load_any();
      step_once();
      load_any();
      load_any();
      step_once();

      settle();
      write_csr(CSR_SIGMA, 10);
      write_csr(CSR_RHO, 28);
      write_csr(CSR_BETA, 3);
      write_csr(CSR_STEP_SIZE, 1678);
      write_csr(CSR_ZOOM_X, 1023);
      write_csr(CSR_ZOOM_Y, 1023);
      write_csr(CSR_ORIGIN_X, -32768);
      write_csr(CSR_ORIGIN_Y, 32767);
      send(REQ_LOAD, 32'sd0, Q_MAX, Q_MIN);
      repeat (2) step_once();

      // Random phases: mostly trajectories from sensible start points, some wild mixes.
      while (items_sent < ITEM_TARGET) begin
         phase++;
         settle();
         if (items_sent > ITEM_TARGET - 250) begin
            req_idle_on = 1'b0;
            rsp_idle_on = 1'b0;
         end else begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         tame = ($urandom_range(0, 9) < 7) || phase == 2 || phase == 7;
         random_config(tame);
         // Hold the output long enough for the block to back up into its input.
         if (phase == 2 || phase == 7) rsp_hold_req = 1'b1;
         if (tame) begin
            repeat ($urandom_range(2, 4)) begin
               if ($urandom_range(0, 4) == 0) load_any();
               else load_tame();
               repeat ($urandom_range(10, 50)) step_once();
            end
         end else begin
            repeat ($urandom_range(20, 60)) begin
               if ($urandom_range(0, 1) == 0) load_any();
               else step_once();
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      $display("Checked %0d plot points from %0d step and %0d load words, %0d register writes.",
               sb.points_checked, sb.steps_seen, sb.loads_seen, sb.reg_writes);
      $display("Covered reset defaults, zero and full-scale registers, %0d register settings.",
               settings_used);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("lorenz_euler_plotter_core verification clean");
      end else begin
         $display("lorenz_euler_plotter_core verification failed");
      end
      $finish;
   end

endmodule
